### hw/rtl/fc32_pkg.sv
// Shared constants and the 16-bit fold helper for the Fletcher-32 checksum unit.
// No dependencies; imported by fletcher32_checksum_unit.
package fc32_pkg;

    localparam int SUM_W          = 32;
    localparam int WORD_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int FOLD_BYTES_DEF = 360;

    localparam logic [SUM_W-1:0] SUM_INIT = 32'h0000_ffff;

    // Low half plus high half; the carry lands in bit 16.
    function automatic logic [SUM_W-1:0] fold16(input logic [SUM_W-1:0] x);
        logic [WORD_W:0] s;
        s = {1'b0, x[WORD_W-1:0]} + {1'b0, x[SUM_W-1:WORD_W]};
        return {{(SUM_W-WORD_W-1){1'b0}}, s};
    endfunction

endpackage

### hw/rtl/fletcher32_checksum_unit.sv
// Streaming Fletcher-32 checksum unit: byte pairing, accumulate, periodic fold,
// final fold and output register. Depends on fc32_pkg.
//
// A last byte reaches m_valid via the finish register (accumulate) and then the
// output register (final folds). One byte per cycle, but a last byte waits while
// the finish register is held; sums and fold sit in the single accumulate stage.
// Reset (aresetn low, synchronous): sums return to 0xffff, byte count and held
// byte clear, all stages empty. Each message restarts from the same state.
module fletcher32_checksum_unit #(
    parameter int FOLD_BYTES = fc32_pkg::FOLD_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fc32_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fc32_pkg::SUM_W-1:0]    m_checksum
);
    import fc32_pkg::*;

    // Count width: holds up to FOLD_BYTES + 1 before it is cleared.
    localparam int CNT_W = $clog2(FOLD_BYTES + 2);
    localparam logic [CNT_W-1:0] FOLD_LIMIT = CNT_W'(FOLD_BYTES);
    localparam logic [CNT_W-1:0] CNT_STEP   = CNT_W'(2);

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg, in_data_next;
    logic              in_last_reg, in_last_next;

    // Running state
    logic [SUM_W-1:0]  low_sum_reg, low_sum_next;
    logic [SUM_W-1:0]  high_sum_reg, high_sum_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              odd_phase_reg, odd_phase_next;

    // Finish register, one message end waiting for its final folds
    logic              fin_valid_reg, fin_valid_next;
    logic [SUM_W-1:0]  fin_low_reg, fin_low_next;
    logic [SUM_W-1:0]  fin_high_reg, fin_high_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  out_sum_reg, out_sum_next;

    // Stage handshakes
    logic out_load, fin_adv, acc_fire, in_take;

    // Accumulate datapath
    logic              acc_en;
    logic [WORD_W-1:0] word;
    logic [SUM_W-1:0]  low_add, high_add, low_acc, high_acc;
    logic [CNT_W-1:0]  cnt_add, cnt_acc;
    logic              fold_hit;
    logic [SUM_W-1:0]  fin_low_f1, fin_high_f1, fin_low_f2, fin_high_f2;

    // Flow control: non-last bytes never wait on the output side
    assign out_load = fin_valid_reg && (!out_valid_reg || m_ready);
    assign fin_adv  = !fin_valid_reg || out_load;
    assign acc_fire = in_valid_reg && (!in_last_reg || fin_adv);
    assign in_take  = s_valid && s_ready;
    assign s_ready  = !in_valid_reg || acc_fire;

    assign m_valid    = out_valid_reg;
    assign m_checksum = out_sum_reg;

    // Pairing and accumulate with the periodic fold
    always_comb begin
        acc_en   = odd_phase_reg || in_last_reg;
        word     = odd_phase_reg ? {in_data_reg, held_byte_reg}
                                 : {{(WORD_W-BYTE_W){1'b0}}, in_data_reg};
        low_add  = low_sum_reg + {{(SUM_W-WORD_W){1'b0}}, word};
        high_add = high_sum_reg + low_add;
        cnt_add  = byte_count_reg + CNT_STEP;
        fold_hit = cnt_add >= FOLD_LIMIT;
        if (!acc_en) begin
            low_acc  = low_sum_reg;
            high_acc = high_sum_reg;
            cnt_acc  = byte_count_reg;
        end else if (fold_hit) begin
            low_acc  = fold16(low_add);
            high_acc = fold16(high_add);
            cnt_acc  = '0;
        end else begin
            low_acc  = low_add;
            high_acc = high_add;
            cnt_acc  = cnt_add;
        end
    end

    // Final two folds for the output register
    always_comb begin
        fin_low_f1  = fold16(fin_low_reg);
        fin_high_f1 = fold16(fin_high_reg);
        fin_low_f2  = fold16(fin_low_f1);
        fin_high_f2 = fold16(fin_high_f1);
    end

    // Next-state selection
    always_comb begin
        in_valid_next   = in_valid_reg;
        in_data_next    = in_data_reg;
        in_last_next    = in_last_reg;
        low_sum_next    = low_sum_reg;
        high_sum_next   = high_sum_reg;
        byte_count_next = byte_count_reg;
        held_byte_next  = held_byte_reg;
        odd_phase_next  = odd_phase_reg;
        fin_valid_next  = fin_valid_reg;
        fin_low_next    = fin_low_reg;
        fin_high_next   = fin_high_reg;
        out_valid_next  = out_valid_reg;
        out_sum_next    = out_sum_reg;

        // output stage
        if (out_load) begin
            out_valid_next = 1'b1;
            out_sum_next   = {fin_high_f2[WORD_W-1:0], fin_low_f2[WORD_W-1:0]};
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        // finish stage empties when its result moves on
        if (out_load) begin
            fin_valid_next = 1'b0;
        end

        // accumulate stage
        if (acc_fire) begin
            if (in_last_reg) begin
                fin_valid_next  = 1'b1;
                fin_low_next    = low_acc;
                fin_high_next   = high_acc;
                low_sum_next    = SUM_INIT;
                high_sum_next   = SUM_INIT;
                byte_count_next = '0;
                held_byte_next  = '0;
                odd_phase_next  = 1'b0;
            end else if (odd_phase_reg) begin
                low_sum_next    = low_acc;
                high_sum_next   = high_acc;
                byte_count_next = cnt_acc;
                held_byte_next  = '0;
                odd_phase_next  = 1'b0;
            end else begin
                held_byte_next  = in_data_reg;
                odd_phase_next  = 1'b1;
            end
        end

        // input register
        if (in_take) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data_byte;
            in_last_next  = s_last_byte;
        end else if (acc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            low_sum_reg    <= SUM_INIT;
            high_sum_reg   <= SUM_INIT;
            byte_count_reg <= '0;
            held_byte_reg  <= '0;
            odd_phase_reg  <= 1'b0;
            fin_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            low_sum_reg    <= low_sum_next;
            high_sum_reg   <= high_sum_next;
            byte_count_reg <= byte_count_next;
            held_byte_reg  <= held_byte_next;
            odd_phase_reg  <= odd_phase_next;
            fin_valid_reg  <= fin_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        in_last_reg  <= in_last_next;
        fin_low_reg  <= fin_low_next;
        fin_high_reg <= fin_high_next;
        out_sum_reg  <= out_sum_next;
    end

`ifndef NO_ASSERTIONS
    // A finished message leaves the sums re-initialized
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_fire && in_last_reg |=> low_sum_reg == SUM_INIT && high_sum_reg == SUM_INIT
                                    && byte_count_reg == '0 && !odd_phase_reg)
        else $error("state not re-initialized after last byte");

    // Byte count stays even and below the fold interval
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg < FOLD_LIMIT && !byte_count_reg[0])
        else $error("byte count out of range");

    // A last byte always lands in the finish register
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_fire && in_last_reg |=> fin_valid_reg)
        else $error("finished message lost");

    // A finish entry moving on shows up at the output
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && m_checksum == $past({fin_high_f2[WORD_W-1:0],
                                                     fin_low_f2[WORD_W-1:0]}))
        else $error("checksum not loaded");

    // Non-last bytes never stall behind a waiting result
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_last_reg |-> s_ready)
        else $error("input stalled without cause");
`endif

endmodule
